/* rtl/cosine_taylor_series_macros.svh */
// Assertion macros shared by the cosine Taylor series RTL.
`ifndef COSINE_TAYLOR_SERIES_MACROS_SVH
`define COSINE_TAYLOR_SERIES_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cos_tay_pkg.sv */
// Types, constants and per-term divider tables for the cosine Taylor series block.
package cos_tay_pkg;

  localparam int MAX_TERMS  = 12;
  localparam int FRAC_BITS  = 30;
  localparam int ANGLE_W    = 32;
  localparam int COS_W      = 32;
  localparam int CNT_W      = 4;
  localparam int X_W        = 38;  // angle in Q8.30
  localparam int X2_W       = 34;  // x^2 below pi^2
  localparam int TERM_W     = 34;  // largest term below 5.0
  localparam int P_W        = 37;  // term times x^2, before the divide
  localparam int SUM_W      = 36;
  localparam int RED_STAGES = 7;
  localparam int RED_IDX_W  = 3;
  localparam int RECIP_W    = 32;
  localparam int DIV_W      = 10;
  localparam int SHIFT_W    = 6;
  localparam int FIX_W      = 3;
  localparam int FIX_MAX    = 7;

  localparam logic [CNT_W-1:0] TERM_COUNT_RST = 4'd8;
  localparam logic [CNT_W-1:0] CNT_MAX        = CNT_W'(MAX_TERMS);

  // pi rounded to 30 fraction bits, and twice that
  localparam logic [X_W-1:0] PI_FX     = 38'd3373259426;
  localparam logic [X_W-1:0] TWO_PI_FX = 38'd6746518852;

  localparam logic signed [SUM_W-1:0] ONE_FX = 36'sd1073741824;

  // word in the range reduction pipe
  typedef struct packed {
    logic [X_W-1:0]   x;
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } red_t;

  // word in the series pipe
  typedef struct packed {
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]  sum;
    logic                     neg;
    logic [CNT_W-1:0]         cnt;
  } tay_t;

  // bound subtracted at each reduction step: 2pi*32 down to 2pi, then pi
  function automatic logic [X_W-1:0] red_bound(input logic [RED_IDX_W-1:0] idx);
    logic [X_W-1:0] b;
    if (idx == RED_IDX_W'(RED_STAGES - 1)) begin
      b = PI_FX;
    end else begin
      b = TWO_PI_FX << (RED_IDX_W'(RED_STAGES - 2) - idx);
    end
    return b;
  endfunction

  // divisor (2k-1)*2k of term k
  function automatic logic [DIV_W-1:0] term_div(input logic [CNT_W-1:0] k);
    logic [DIV_W-1:0] d;
    unique case (k)
      4'd1:    d = 10'd2;
      4'd2:    d = 10'd12;
      4'd3:    d = 10'd30;
      4'd4:    d = 10'd56;
      4'd5:    d = 10'd90;
      4'd6:    d = 10'd132;
      4'd7:    d = 10'd182;
      4'd8:    d = 10'd240;
      4'd9:    d = 10'd306;
      4'd10:   d = 10'd380;
      4'd11:   d = 10'd462;
      4'd12:   d = 10'd552;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

  // floor(2^s / d), never above the true reciprocal
  function automatic logic [RECIP_W-1:0] term_recip(input logic [CNT_W-1:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      4'd1:    m = 32'd2147483648;
      4'd2:    m = 32'd1431655765;
      4'd3:    m = 32'd1145324612;
      4'd4:    m = 32'd1227133513;
      4'd5:    m = 32'd1527099483;
      4'd6:    m = 32'd2082408385;
      4'd7:    m = 32'd1510318170;
      4'd8:    m = 32'd1145324612;
      4'd9:    m = 32'd1796587627;
      4'd10:   m = 32'd1446725826;
      4'd11:   m = 32'd1189947649;
      4'd12:   m = 32'd1991868890;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  // shift s paired with the reciprocal
  function automatic logic [SHIFT_W-1:0] term_shift(input logic [CNT_W-1:0] k);
    logic [SHIFT_W-1:0] s;
    unique case (k)
      4'd1:    s = 6'd32;
      4'd2:    s = 6'd34;
      4'd3:    s = 6'd35;
      4'd4:    s = 6'd36;
      4'd5:    s = 6'd37;
      4'd6:    s = 6'd38;
      4'd7:    s = 6'd38;
      4'd8:    s = 6'd38;
      4'd9:    s = 6'd39;
      4'd10:   s = 6'd39;
      4'd11:   s = 6'd39;
      4'd12:   s = 6'd40;
      default: s = 6'd32;
    endcase
    return s;
  endfunction

endpackage

/* rtl/cos_tay_reduce.sv */
// Range reduction modulo 2pi and pi, then squaring of the reduced angle.
module cos_tay_reduce (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cos_tay_pkg::ANGLE_W-1:0]       angle,
  input  logic [cos_tay_pkg::CNT_W-1:0]         cnt,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cos_tay_pkg::tay_t                     out_item
);
  import cos_tay_pkg::*;

  red_t  st_r   [RED_STAGES];
  logic  v_r    [RED_STAGES];
  logic  rdy    [RED_STAGES+1];
  red_t  head;
  tay_t  sq_r;
  tay_t  sq_nxt;
  logic  sq_v_r;
  logic [2*ANGLE_W-1:0] sq_full;

  // angle to Q8.30, term count clamped
  always_comb begin
    head.x   = X_W'(angle) << (FRAC_BITS - 24);
    head.neg = 1'b0;
    head.cnt = (cnt > CNT_MAX) ? CNT_MAX : cnt;
  end

  assign in_ready = rdy[0];

  // one conditional subtract per stage
  for (genvar i = 0; i < RED_STAGES; i++) begin : g_red
    red_t src;
    logic src_v;
    red_t st_nxt;

    if (i == 0) begin : g_first
      assign src   = head;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st_r[i-1];
      assign src_v = v_r[i-1];
    end

    always_comb begin
      st_nxt = src;
      if (src.x >= red_bound(RED_IDX_W'(i))) begin
        st_nxt.x = src.x - red_bound(RED_IDX_W'(i));
        if (i == RED_STAGES - 1) begin
          st_nxt.neg = 1'b1;
        end
      end
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  // x^2 in Q.30, series starts at one
  assign sq_full = st_r[RED_STAGES-1].x[ANGLE_W-1:0] * st_r[RED_STAGES-1].x[ANGLE_W-1:0];

  always_comb begin
    sq_nxt.x2   = sq_full[FRAC_BITS +: X2_W];
    sq_nxt.term = TERM_W'(ONE_FX);
    sq_nxt.sum  = ONE_FX;
    sq_nxt.neg  = st_r[RED_STAGES-1].neg;
    sq_nxt.cnt  = st_r[RED_STAGES-1].cnt;
  end

  assign rdy[RED_STAGES] = !sq_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (rdy[RED_STAGES]) begin
      sq_v_r <= v_r[RED_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[RED_STAGES]) begin
      sq_r <= sq_nxt;
    end
  end

  assign out_valid = sq_v_r;
  assign out_item  = sq_r;

endmodule

/* rtl/cos_tay_term.sv */
// One Taylor term: multiply by x^2, divide by (2k-1)*2k, accumulate; three stages.
module cos_tay_term (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cos_tay_pkg::CNT_W-1:0] k,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cos_tay_pkg::tay_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cos_tay_pkg::tay_t             out_item
);
  import cos_tay_pkg::*;

  localparam int PROD_A_W = TERM_W + X2_W;
  localparam int PROD_B_W = P_W + RECIP_W;
  localparam int QD_W     = P_W + DIV_W;
  localparam int R_W      = QD_W + 1;

  logic [DIV_W-1:0]    d;
  logic [RECIP_W-1:0]  recip;
  logic [SHIFT_W-1:0]  shift;

  tay_t             a_r, b_r, c_r, c_nxt;
  logic [P_W-1:0]   a_p_r, b_p_r, b_q_r;
  logic             a_v_r, b_v_r, c_v_r;
  logic             rdy_a, rdy_b, rdy_c;
  logic [PROD_A_W-1:0] prod_a;
  logic [PROD_B_W-1:0] prod_b;
  logic [QD_W-1:0]     qd;
  logic signed [R_W-1:0] rem;
  logic [FIX_W-1:0]    fix;
  logic [P_W-1:0]      q;

  assign d     = term_div(k);
  assign recip = term_recip(k);
  assign shift = term_shift(k);

  assign rdy_c    = !c_v_r || out_ready;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_ready = rdy_a;

  // stage A: previous term times x^2
  assign prod_a = in_item.term * in_item.x2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_r   <= in_item;
      a_p_r <= prod_a[FRAC_BITS +: P_W];
    end
  end

  // stage B: quotient estimate by reciprocal
  assign prod_b = a_p_r * recip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (rdy_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_r   <= a_r;
      b_p_r <= a_p_r;
      b_q_r <= P_W'(prod_b >> shift);
    end
  end

  // stage C: fix the estimate from the remainder, then add or subtract
  assign qd  = b_q_r * d;
  assign rem = $signed({{(R_W-P_W){1'b0}}, b_p_r}) - $signed({1'b0, qd});

  always_comb begin
    fix = '0;
    for (int j = 1; j <= FIX_MAX; j++) begin
      if (rem >= $signed({{(R_W-DIV_W){1'b0}}, d} * R_W'(j))) begin
        fix = FIX_W'(j);
      end
    end
  end

  always_comb begin
    if (rem < 0) begin
      q = b_q_r - P_W'(1);
    end else begin
      q = b_q_r + P_W'(fix);
    end
  end

  always_comb begin
    c_nxt = b_r;
    if (k <= b_r.cnt) begin
      c_nxt.term = q[TERM_W-1:0];
      if (k[0]) begin
        c_nxt.sum = b_r.sum - $signed({{(SUM_W-TERM_W){1'b0}}, q[TERM_W-1:0]});
      end else begin
        c_nxt.sum = b_r.sum + $signed({{(SUM_W-TERM_W){1'b0}}, q[TERM_W-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (rdy_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_r <= c_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_item  = c_r;

endmodule

/* rtl/cosine_taylor_series.sv */
// Cosine by truncated Taylor series: top level with channels, term register and output stage.
//
// Use: angle words (unsigned Q8.24 radians) enter on in_tvalid/in_tready/in_tdata;
// cosine words (signed Q2.30, within plus or minus one) leave on the out_ group.
// cfg_valid/cfg_ready/cfg_data write the term count (1 to 12 useful, above 12 acts
// as 12, 0 gives exactly plus or minus one); write it only while the block is idle.
// From acceptance to out_tvalid a word passes the reduction modulo 2pi and pi, the square,
// the A, B and C registers of each of the 12 term stages, and 1 output register.
// Throughput is one word per cycle while out_tready holds high; every term has its own
// multipliers, so nothing is shared and no item waits on another.
// Reset clears all valid bits and sets the term count to 8; cfg_ready stays high.
// When the receiver holds out_tready low, the output word holds and the stall walks
// back stage by stage; empty stages still fill, so in_tready drops only once every
// stage holds a word.
`include "cosine_taylor_series_macros.svh"

module cosine_taylor_series (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cos_tay_pkg::ANGLE_W-1:0]   in_tdata,   // [31:0] angle
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cos_tay_pkg::COS_W-1:0]     out_tdata,  // [31:0] cosine
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cos_tay_pkg::CNT_W-1:0]     cfg_data
);
  import cos_tay_pkg::*;

  logic [CNT_W-1:0] term_count_r;

  tay_t link_item  [MAX_TERMS+1];
  logic link_valid [MAX_TERMS+1];
  logic link_ready [MAX_TERMS+1];

  logic                     out_tvalid_r;
  logic [COS_W-1:0]         out_tdata_r;
  logic [COS_W-1:0]         out_tdata_nxt;
  logic                     out_rdy;

  // term count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RST;
    end else if (cfg_valid) begin
      term_count_r <= cfg_data;
    end
  end

  // range reduction and square
  cos_tay_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .angle     (in_tdata),
    .cnt       (term_count_r),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_item  (link_item[0])
  );

  // one stage group per term
  for (genvar t = 1; t <= MAX_TERMS; t++) begin : g_term
    cos_tay_term u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .k         (CNT_W'(t)),
      .in_valid  (link_valid[t-1]),
      .in_ready  (link_ready[t-1]),
      .in_item   (link_item[t-1]),
      .out_valid (link_valid[t]),
      .out_ready (link_ready[t]),
      .out_item  (link_item[t])
    );
  end

  // saturate, fold sign, to Q2.30
  always_comb begin
    logic signed [SUM_W-1:0] s_cl;
    logic                    neg;
    logic [COS_W-1:0]        mag;
    s_cl = link_item[MAX_TERMS].sum;
    neg  = link_item[MAX_TERMS].neg;
    if (s_cl > ONE_FX) begin
      s_cl = ONE_FX;
    end else if (s_cl < -ONE_FX) begin
      s_cl = -ONE_FX;
    end
    if (s_cl < 0) begin
      neg  = !neg;
      s_cl = -s_cl;
    end
    mag = COS_W'(s_cl[FRAC_BITS:0]);
    out_tdata_nxt = neg ? (~mag + COS_W'(1)) : mag;
  end

  // output register
  assign out_rdy               = !out_tvalid_r || out_tready;
  assign link_ready[MAX_TERMS] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_rdy) begin
      out_tvalid_r <= link_valid[MAX_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `CTS_ASSERT_IMPL(a_cos_range, out_tvalid, ($signed(out_tdata) <= 32'sd1073741824) && ($signed(out_tdata) >= -32'sd1073741824), "cosine word outside plus or minus one")
  `CTS_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, term_count_r == $past(cfg_data), "term count not taken from the written word")

endmodule

/* dv/cosine_taylor_series_checker.sv */
// Checker for the cosine Taylor series block: predicts each cosine word and compares.
`timescale 1ns / 1ps

module cosine_taylor_series_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [cos_tay_pkg::ANGLE_W-1:0] in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cos_tay_pkg::COS_W-1:0]   out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cos_tay_pkg::CNT_W-1:0]   cfg_data,
  output int                              fail_count,
  output int                              pending_count,
  output int                              cosine_count
);
  import cos_tay_pkg::*;

  logic [CNT_W-1:0]  terms_now;
  logic [COS_W-1:0]  cosine_q[$];

  // pi to 30 fraction bits, rounded
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return 64'(p >> FRAC_BITS);
  endfunction

  // Taylor sum in Q30, saturated, with sign folding
  function automatic logic [COS_W-1:0] predict_cosine(input logic [ANGLE_W-1:0] ang,
                                                      input logic [CNT_W-1:0] n);
    logic [63:0]       x, x2, t, mag;
    logic signed [63:0] s;
    logic              flip;
    int                lim;
    flip = 1'b0;
    x = {32'd0, ang} << (FRAC_BITS - 24);
    x = x % (2 * PI_Q30);
    if (x >= PI_Q30) begin
      x = x - PI_Q30;
      flip = 1'b1;
    end
    lim = (n > MAX_TERMS) ? MAX_TERMS : n;
    x2 = fx_mul(x, x);
    t = 64'd1 << FRAC_BITS;
    s = 64'sd1 << FRAC_BITS;
    for (int k = 1; k <= lim; k++) begin
      t = fx_mul(t, x2) / ((2 * k - 1) * (2 * k));
      if (k % 2) s = s - $signed(t);
      else s = s + $signed(t);
    end
    if (s > (64'sd1 <<< FRAC_BITS)) s = 64'sd1 <<< FRAC_BITS;
    if (s < -(64'sd1 <<< FRAC_BITS)) s = -(64'sd1 <<< FRAC_BITS);
    if (s < 0) begin
      mag = -s;
      flip = !flip;
    end else begin
      mag = s;
    end
    if (flip) mag = -mag;
    return mag[COS_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_count = cosine_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      terms_now <= TERM_COUNT_RST;
      cosine_q.delete();
      fail_count <= 0;
      cosine_count <= 0;
    end else begin
      // term count write
      if (cfg_valid && cfg_ready) terms_now <= cfg_data;
      // accepted angle word
      if (in_tvalid && in_tready) cosine_q.push_back(predict_cosine(in_tdata, terms_now));
      // accepted cosine word
      if (out_tvalid && out_tready) begin
        cosine_count <= cosine_count + 1;
        if (cosine_q.size() == 0) begin
          report_mismatch($sformatf("unexpected cosine %h", out_tdata));
        end else begin
          if (out_tdata !== cosine_q[0])
            report_mismatch($sformatf("cosine got %h want %h", out_tdata, cosine_q[0]));
          void'(cosine_q.pop_front());
        end
      end
    end
  end
endmodule

/* dv/tb_cosine_taylor_series.sv */
// Testbench top for the cosine Taylor series block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_cosine_taylor_series;
  import cos_tay_pkg::*;

  localparam int LATENCY   = 45;
  localparam int WD_LIMIT  = 5000;
  localparam int N_RANDOM  = 1625;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ANGLE_W-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [COS_W-1:0]    out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data = '0;
  int                  fail_count, pending_count, cosine_count;
  int                  idle_run;
  bit                  calm;
  bit                  hold_off;
  bit                  done;

  always #1 clk = ~clk;

  cosine_taylor_series dut (.*);

  cosine_taylor_series_checker u_chk (.*);

  // write the term count while idle
  task automatic write_terms(input logic [CNT_W-1:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one angle word, with random gaps before it
  task automatic send_angle(input logic [ANGLE_W-1:0] a);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] rand_angle;
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 32'h0700_0000);   // up to 7 rad
      2:       return $urandom_range(0, 32'h0400_0000);   // up to 4 rad
      default: return {8'($urandom_range(0, 255)), 24'(0)} + $urandom_range(0, 3);
    endcase
  endfunction

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || done
        || pending_count == 0 && !in_tvalid)
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WD_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("[cosine_taylor_series] ERROR");
      $finish;
    end
  end

  initial begin
    logic [ANGLE_W-1:0] corners[$];
    logic [CNT_W-1:0]   settings[$];
    calm = 1'b0;
    done = 1'b0;
    hold_off = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, extremes, near pi and 2pi, saturation, reset term count
    corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0324_3F6A, 32'h0324_3F6B, 32'h0648_7ED5, 32'h0648_7ED4,
                32'h0192_1FB5, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000,
                32'h0500_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (corners[i]) send_angle(corners[i]);
    drain();
    // no terms, too many terms, largest legal
    write_terms(4'd0);
    foreach (corners[i]) if (i < 4) send_angle(corners[i]);
    drain();
    write_terms(4'd15);
    send_angle(32'h0300_0000);
    send_angle(32'hFFFF_FFFF);
    drain();

    // random phases across term settings; long hold-off in the first
    settings = '{4'd1, 4'd12, 4'd2, 4'd13, 4'd5, 4'd8, 4'd3, 4'd0, 4'd12, 4'd1};
    foreach (settings[p]) begin
      write_terms(settings[p]);
      if (p == 0) hold_off = 1'b1;
      if (p == settings.size() - 1) calm = 1'b1;
      repeat (N_RANDOM / settings.size()) begin
        if (p < 8) send_angle(rand_angle());
        else send_angle(32'($urandom_range(0, 3)) << ($urandom_range(0, 30)));
      end
      drain();
    end
    done = 1'b1;

    $display("covered %0d cosine words over term counts 0 to 15, angle extremes",
             cosine_count);
    $display("and a long output stall that back-pressured the input");
    if (fail_count == 0)
      $display("[cosine_taylor_series] OK");
    else
      $display("[cosine_taylor_series] ERROR");
    $finish;
  end
endmodule
